// ===== hw/rtl/vns_pkg.sv =====
// Shared types and constants for the nearest seed search block.
`default_nettype none

package vns_pkg;

  localparam int unsigned SLOT_W = 8;
  localparam int unsigned XY_W = 12;
  localparam int unsigned DIST_W = 25;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_COUNT = 1'd1;

  typedef enum logic {
    METRIC_EUCLID    = 1'b0,
    METRIC_MANHATTAN = 1'b1
  } metric_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_RESULT
  } back_state_e;

  typedef struct packed {
    metric_e          metric;
    logic [CNT_W-1:0] seed_count;
  } cfg_t;

  // One decoded command: a load carries seed coordinates, a query the pixel.
  typedef struct packed {
    logic              is_query;
    logic [SLOT_W-1:0] slot;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vns_in_if.sv =====
// Input channel: seed loads and pixel queries.
`default_nettype none

interface vns_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [vns_pkg::SLOT_W-1:0] seed_slot;
  logic [vns_pkg::XY_W-1:0]   seed_x;
  logic [vns_pkg::XY_W-1:0]   seed_y;
  logic [vns_pkg::XY_W-1:0]   pixel_x;
  logic [vns_pkg::XY_W-1:0]   pixel_y;

  modport source (
    output valid, action, seed_slot, seed_x, seed_y, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, action, seed_slot, seed_x, seed_y, pixel_x, pixel_y,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/vns_out_if.sv =====
// Result channel: nearest seed of a query.
`default_nettype none

interface vns_out_if;
  logic                       valid;
  logic                       ready;
  logic [vns_pkg::SLOT_W-1:0] nearest_slot;
  logic [vns_pkg::XY_W-1:0]   nearest_x;
  logic [vns_pkg::XY_W-1:0]   nearest_y;
  logic [vns_pkg::DIST_W-1:0] nearest_distance;

  modport source (
    output valid, nearest_slot, nearest_x, nearest_y, nearest_distance,
    input  ready
  );
  modport sink (
    input  valid, nearest_slot, nearest_x, nearest_y, nearest_distance,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/vns_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module vns_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vns_front.sv =====
// Front end: accepts input transfers, decodes them and queues commands.
`default_nettype none

module vns_front #(
  parameter int unsigned MAX_SEEDS = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  vns_in_if.sink             in_i,
  output      logic          cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output      vns_pkg::cmd_t cmd_o
);

  localparam logic [16:0] MaxSeedsExt = 17'(MAX_SEEDS);

  vns_pkg::cmd_t                        fifo_q [vns_pkg::FIFO_DEPTH];
  logic [vns_pkg::FIFO_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [vns_pkg::FIFO_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [vns_pkg::FIFO_CNT_W-1:0]       cnt_q, cnt_d;
  logic                                 in_xfer, keep, push, pop;
  vns_pkg::cmd_t                        cmd_new;

  assign in_i.ready = (cnt_q != vns_pkg::FIFO_CNT_W'(vns_pkg::FIFO_DEPTH));
  assign in_xfer    = in_i.valid & in_i.ready;

  // A load aimed past the end of the table is accepted and dropped here.
  assign keep = (in_i.action == vns_pkg::ACT_QUERY) ||
                (17'(in_i.seed_slot) < MaxSeedsExt);

  always_comb begin
    cmd_new.is_query = (in_i.action == vns_pkg::ACT_QUERY);
    cmd_new.slot     = in_i.seed_slot;
    if (in_i.action == vns_pkg::ACT_QUERY) begin
      cmd_new.x = in_i.pixel_x;
      cmd_new.y = in_i.pixel_y;
    end else begin
      cmd_new.x = in_i.seed_x;
      cmd_new.y = in_i.seed_y;
    end
  end

  assign push        = in_xfer & keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vns_back.sv =====
// Back end: seed table writes and the pipelined nearest seed scan.
`default_nettype none

module vns_back #(
  parameter int unsigned MAX_SEEDS  = 256,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire vns_pkg::cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  output      logic          cmd_ready_o,
  input  wire vns_pkg::cmd_t cmd_i,
  vns_out_if.source          out_o
);

  localparam int unsigned IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = SQ_W + 1;
  localparam logic [16:0] MaxSeedsExt = 17'(MAX_SEEDS);

  vns_pkg::back_state_e state_q, state_d;
  logic cmd_xfer, start, ram_we, res_load;

  // Scan issue
  logic [IDX_W-1:0]      issue_idx_q, issue_idx_d, last_idx_q, last_idx_d;
  logic                  issue_on_q, issue_on_d;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [16:0]           count_ext, count_eff;

  // Pipeline stages: table read, distance parts, squares, compare.
  logic                  s1_valid_q, s1_last_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic [SQ_W-1:0]       rdata;
  logic [COORD_BITS-1:0] rd_x, rd_y;

  logic                  s2_valid_q, s2_last_q;
  logic [IDX_W-1:0]      s2_idx_q;
  logic [COORD_BITS-1:0] s2_x_q, s2_y_q, dx_q, dy_q;

  logic                  s3_valid_q, s3_last_q;
  logic [IDX_W-1:0]      s3_idx_q;
  logic [COORD_BITS-1:0] s3_x_q, s3_y_q;
  logic [SQ_W-1:0]       term_a_q, term_b_q;
  logic [SUM_W-1:0]      dist_sum;

  logic [IDX_W-1:0]      best_idx_q;
  logic [COORD_BITS-1:0] best_x_q, best_y_q;
  logic [SUM_W-1:0]      best_dist_q;
  logic                  take;

  logic                  out_valid_q, out_valid_d;

  assign cmd_xfer = cmd_valid_i & cmd_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vns_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.is_query) begin
          state_d = vns_pkg::BK_SCAN;
        end
      end
      vns_pkg::BK_SCAN: begin
        if (s3_valid_q && s3_last_q) begin
          state_d = vns_pkg::BK_RESULT;
        end
      end
      vns_pkg::BK_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = vns_pkg::BK_IDLE;
        end
      end
      default: state_d = vns_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    res_load    = 1'b0;
    case (state_q)
      vns_pkg::BK_IDLE:   cmd_ready_o = 1'b1;
      vns_pkg::BK_SCAN:   cmd_ready_o = 1'b0;
      vns_pkg::BK_RESULT: res_load = !out_valid_q || out_o.ready;
      default:            cmd_ready_o = 1'b0;
    endcase
  end

  assign start  = cmd_xfer & cmd_i.is_query;
  assign ram_we = cmd_xfer & ~cmd_i.is_query;

  // A seed count of zero scans seed zero alone; counts past the table saturate.
  always_comb begin
    count_ext = 17'(cfg_i.seed_count);
    if (count_ext == '0) begin
      count_eff = 17'd1;
    end else if (count_ext > MaxSeedsExt) begin
      count_eff = MaxSeedsExt;
    end else begin
      count_eff = count_ext;
    end
  end

  always_comb begin
    issue_idx_d = issue_idx_q;
    issue_on_d  = issue_on_q;
    last_idx_d  = last_idx_q;
    if (start) begin
      issue_idx_d = '0;
      issue_on_d  = 1'b1;
      last_idx_d  = IDX_W'(count_eff - 17'd1);
    end else if (issue_on_q) begin
      issue_idx_d = issue_idx_q + 1'b1;
      if (issue_idx_q == last_idx_q) begin
        issue_on_d = 1'b0;
      end
    end
  end

  vns_ram #(
    .WIDTH (SQ_W),
    .DEPTH (MAX_SEEDS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(cmd_i.slot)),
    .wdata_i ({COORD_BITS'(cmd_i.x), COORD_BITS'(cmd_i.y)}),
    .re_i    (issue_on_q),
    .raddr_i (issue_idx_q),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[SQ_W-1:COORD_BITS];
  assign rd_y = rdata[COORD_BITS-1:0];

  assign dist_sum = SUM_W'(term_a_q) + SUM_W'(term_b_q);
  // Strict compare keeps the earliest seed on a tie.
  assign take = (s3_idx_q == '0) || (dist_sum < best_dist_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vns_pkg::BK_IDLE;
      issue_on_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_on_q  <= issue_on_d;
      s1_valid_q  <= issue_on_q;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_idx_q <= issue_idx_d;
    last_idx_q  <= last_idx_d;
    if (start) begin
      px_q <= COORD_BITS'(cmd_i.x);
      py_q <= COORD_BITS'(cmd_i.y);
    end

    s1_idx_q  <= issue_idx_q;
    s1_last_q <= (issue_idx_q == last_idx_q);

    s2_idx_q  <= s1_idx_q;
    s2_last_q <= s1_last_q;
    s2_x_q    <= rd_x;
    s2_y_q    <= rd_y;
    dx_q      <= (px_q > rd_x) ? (px_q - rd_x) : (rd_x - px_q);
    dy_q      <= (py_q > rd_y) ? (py_q - rd_y) : (rd_y - py_q);

    s3_idx_q  <= s2_idx_q;
    s3_last_q <= s2_last_q;
    s3_x_q    <= s2_x_q;
    s3_y_q    <= s2_y_q;
    if (cfg_i.metric == vns_pkg::METRIC_MANHATTAN) begin
      term_a_q <= SQ_W'(dx_q);
      term_b_q <= SQ_W'(dy_q);
    end else begin
      term_a_q <= dx_q * dx_q;
      term_b_q <= dy_q * dy_q;
    end

    if (s3_valid_q && take) begin
      best_idx_q  <= s3_idx_q;
      best_x_q    <= s3_x_q;
      best_y_q    <= s3_y_q;
      best_dist_q <= dist_sum;
    end

    if (res_load) begin
      out_o.nearest_slot     <= vns_pkg::SLOT_W'(best_idx_q);
      out_o.nearest_x        <= vns_pkg::XY_W'(best_x_q);
      out_o.nearest_y        <= vns_pkg::XY_W'(best_y_q);
      out_o.nearest_distance <= vns_pkg::DIST_W'(best_dist_q);
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/voronoi_nearest_seed_search_top.sv =====
// Top level of the nearest seed search: configuration registers, front and back end.
//
//   channel  direction  contents
//   in_i     in         action, seed_slot, seed_x, seed_y, pixel_x, pixel_y
//   out_o    out        nearest_slot, nearest_x, nearest_y, nearest_distance
//   cfg_*    in         metric_mode (index 0), seed_count (index 1)
//
// A load is written into the seed table straight from the idle state. A query scans the
// active seeds: the table RAM delivers one seed per cycle into a four stage distance and
// compare pipeline. The front end holds up to two decoded commands, so input transfers
// continue, until it is full, while a query scans or a result waits. The seed table is
// not cleared by reset; its entries hold nothing defined until they are loaded.
`default_nettype none

module voronoi_nearest_seed_search_top #(
  parameter int unsigned MAX_SEEDS  = 256,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  vns_in_if.sink                                in_i,
  vns_out_if.source                             out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [vns_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [vns_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  vns_pkg::metric_e              metric_mode_q;
  logic [vns_pkg::CNT_W-1:0]     seed_count_q;
  vns_pkg::cfg_t                 cfg;
  logic                          cmd_valid, cmd_ready;
  vns_pkg::cmd_t                 cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_mode_q <= vns_pkg::METRIC_EUCLID;
      seed_count_q  <= vns_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vns_pkg::CFG_METRIC_MODE: metric_mode_q <= vns_pkg::metric_e'(cfg_wdata_i[0]);
        vns_pkg::CFG_SEED_COUNT:  seed_count_q  <= vns_pkg::CNT_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign cfg.metric     = metric_mode_q;
  assign cfg.seed_count = seed_count_q;

  vns_front #(
    .MAX_SEEDS (MAX_SEEDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  vns_back #(
    .MAX_SEEDS  (MAX_SEEDS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb_voronoi_nearest_seed_search_top.sv =====
// Self-checking testbench for the nearest seed search top level.
`default_nettype none

module tb_voronoi_nearest_seed_search_top;
  import vns_pkg::*;

  localparam int unsigned SEED_SLOTS = 256;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD_CYCLES = 500;
  localparam int unsigned TARGET_ITEMS = 900;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic [XY_W-1:0]   seed_x;
    logic [XY_W-1:0]   seed_y;
    logic [XY_W-1:0]   pixel_x;
    logic [XY_W-1:0]   pixel_y;
  } seed_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [DIST_W-1:0] nearest_dist;
  } nearest_t;

  class nearest_seed_scoreboard;
    metric_e          metric;
    logic [CNT_W-1:0] seed_count;
    logic [XY_W-1:0]  table_x [SEED_SLOTS];
    logic [XY_W-1:0]  table_y [SEED_SLOTS];
    nearest_t         expected_q [$];
    int unsigned      errors;
    int unsigned      results_checked;
    int unsigned      loads_seen;
    int unsigned      queries_seen;

    function new();
      metric = METRIC_EUCLID;
      seed_count = 1;
      errors = 0;
      results_checked = 0;
      loads_seen = 0;
      queries_seen = 0;
    endfunction

    function void set_config(metric_e m, logic [CNT_W-1:0] n);
      metric = m;
      seed_count = n;
    endfunction

    function logic [DIST_W-1:0] distance(logic [XY_W-1:0] px, logic [XY_W-1:0] py,
                                         logic [XY_W-1:0] sx, logic [XY_W-1:0] sy);
      logic [DIST_W-1:0] dx;
      logic [DIST_W-1:0] dy;
      dx = DIST_W'((px > sx) ? px - sx : sx - px);
      dy = DIST_W'((py > sy) ? py - sy : sy - py);
      if (metric == METRIC_MANHATTAN) return dx + dy;
      return dx * dx + dy * dy;
    endfunction

    // Loads update the table; a query scans the active seeds and keeps the
    // first strict minimum, so the lowest slot wins a tie.
    function void note_input(seed_cmd_t c);
      int unsigned       active;
      int unsigned       best;
      logic [DIST_W-1:0] best_dist;
      logic [DIST_W-1:0] d;
      nearest_t          r;
      if (c.action == ACT_LOAD) begin
        table_x[c.slot] = c.seed_x;
        table_y[c.slot] = c.seed_y;
        loads_seen++;
        return;
      end
      queries_seen++;
      active = (seed_count == 0) ? 1 : ((seed_count > SEED_SLOTS) ? SEED_SLOTS : seed_count);
      best = 0;
      best_dist = distance(c.pixel_x, c.pixel_y, table_x[0], table_y[0]);
      for (int unsigned i = 1; i < active; i++) begin
        d = distance(c.pixel_x, c.pixel_y, table_x[i], table_y[i]);
        if (d < best_dist) begin
          best_dist = d;
          best = i;
        end
      end
      r.slot = SLOT_W'(best);
      r.x = table_x[best];
      r.y = table_y[best];
      r.nearest_dist = best_dist;
      expected_q.push_back(r);
    endfunction

    function void check_result(nearest_t got);
      nearest_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no query outstanding: slot %0d distance %0d",
               got.slot, got.nearest_dist);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.slot !== want.slot) begin
        $error("nearest_slot expected %0d actual %0d", want.slot, got.slot);
        errors++;
      end
      if (got.x !== want.x) begin
        $error("nearest_x expected %0d actual %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("nearest_y expected %0d actual %0d", want.y, got.y);
        errors++;
      end
      if (got.nearest_dist !== want.nearest_dist) begin
        $error("nearest_distance expected %0d actual %0d", want.nearest_dist,
               got.nearest_dist);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  vns_in_if  in_if ();
  vns_out_if out_if ();

  voronoi_nearest_seed_search_top #(
    .MAX_SEEDS  (SEED_SLOTS),
    .COORD_BITS (XY_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  nearest_seed_scoreboard sb;
  bit                     no_idle;
  bit                     hold_req;
  int unsigned            items_sent;
  int unsigned            settings_used;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_input('{in_if.action, in_if.seed_slot, in_if.seed_x, in_if.seed_y,
                        in_if.pixel_x, in_if.pixel_y});
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{out_if.nearest_slot, out_if.nearest_x, out_if.nearest_y,
                          out_if.nearest_distance});
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    bit          lvl;
    int unsigned len;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        lvl = 1'b0;
        len = LONG_HOLD_CYCLES;
      end else if (no_idle) begin
        lvl = 1'b1;
        len = 1;
      end else if ($urandom_range(0, 99) < 60) begin
        lvl = 1'b1;
        len = $urandom_range(1, 10);
      end else begin
        lvl = 1'b0;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(15, 60);
      end
      out_if.ready <= lvl;
      repeat (len) @(posedge clk_i);
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [XY_W-1:0] rand_coord(int unsigned style, int unsigned base);
    case (style)
      1: return XY_W'(base + $urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return XY_W'($urandom);
        endcase
      end
      default: return XY_W'($urandom);
    endcase
  endfunction

  // Fields a command does not use still carry random bits.
  function automatic seed_cmd_t seed_load(int unsigned slot, int unsigned x, int unsigned y);
    return '{ACT_LOAD, SLOT_W'(slot), XY_W'(x), XY_W'(y), XY_W'($urandom), XY_W'($urandom)};
  endfunction

  function automatic seed_cmd_t pixel_query(int unsigned x, int unsigned y);
    return '{ACT_QUERY, SLOT_W'($urandom), XY_W'($urandom), XY_W'($urandom),
             XY_W'(x), XY_W'(y)};
  endfunction

  task automatic send_cmd(input seed_cmd_t c);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= c.action;
    in_if.seed_slot <= c.slot;
    in_if.seed_x    <= c.seed_x;
    in_if.seed_y    <= c.seed_y;
    in_if.pixel_x   <= c.pixel_x;
    in_if.pixel_y   <= c.pixel_y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Loads give no result, so an extra drain wait covers any still in flight.
  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input metric_e m, input logic [CNT_W-1:0] n);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_METRIC_MODE;
    // Bits above the mode bit carry random values.
    cfg_wdata_i <= {(CFG_DATA_W-1)'($urandom), m};
    @(posedge clk_i);
    cfg_index_i <= CFG_SEED_COUNT;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(m, n);
    settings_used++;
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input int unsigned n_items,
                           input int unsigned query_pct, input bit clustered);
    int unsigned slot_hi;
    int unsigned base;
    int unsigned style;
    seed_cmd_t   c;
    slot_hi = (count == 0) ? 0 : ((count > SEED_SLOTS) ? SEED_SLOTS - 1 : count - 1);
    base = $urandom_range(0, 4088);
    repeat (n_items) begin
      if (clustered) style = ($urandom_range(0, 99) < 80) ? 1 : 0;
      else style = ($urandom_range(0, 99) < 70) ? 0 : 2;
      if ($urandom_range(0, 99) < query_pct) begin
        c = pixel_query(rand_coord(style, base), rand_coord(style, base));
      end else begin
        c = seed_load(($urandom_range(0, 99) < 80) ? $urandom_range(0, slot_hi)
                                                   : $urandom_range(0, SEED_SLOTS - 1),
                      rand_coord(style, base), rand_coord(style, base));
      end
      send_cmd(c);
    end
  endtask

  initial begin
    int unsigned      phase_idx;
    int unsigned      r;
    int unsigned      n_items;
    logic [CNT_W-1:0] count;
    metric_e          metric;

    sb = new();
    no_idle = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    settings_used = 0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_wdata_i     <= '0;
    in_if.valid     <= 1'b0;
    in_if.action    <= ACT_LOAD;
    in_if.seed_slot <= '0;
    in_if.seed_x    <= '0;
    in_if.seed_y    <= '0;
    in_if.pixel_x   <= '0;
    in_if.pixel_y   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: coordinate extremes, largest distances, zero seed count and a
    // tie between two identical seeds.
    set_config(METRIC_EUCLID, 1);
    send_cmd(seed_load(0, 0, 0));
    send_cmd(pixel_query(0, 0));
    send_cmd(pixel_query(4095, 4095));
    quiesce();
    set_config(METRIC_EUCLID, 0);
    send_cmd(pixel_query(4095, 0));
    send_cmd(seed_load(1, 4095, 4095));
    send_cmd(seed_load(2, 4095, 0));
    send_cmd(seed_load(3, 0, 4095));
    send_cmd(seed_load(4, 4095, 4095));
    quiesce();
    set_config(METRIC_EUCLID, 5);
    send_cmd(pixel_query(4095, 4095));
    send_cmd(pixel_query(2048, 2048));
    send_cmd(pixel_query(2048, 0));
    quiesce();
    set_config(METRIC_MANHATTAN, 5);
    send_cmd(pixel_query(0, 0));
    send_cmd(pixel_query(4095, 4095));
    send_cmd(pixel_query(1000, 3000));
    send_cmd(pixel_query(0, 4095));
    quiesce();
    set_config(METRIC_MANHATTAN, 1);
    send_cmd(pixel_query(4095, 4095));

    // Fill the whole table so that any seed count may be scanned from here on.
    for (int unsigned i = 0; i < SEED_SLOTS; i++) begin
      r = $urandom_range(0, 2);
      send_cmd(seed_load(i, rand_coord(r, $urandom_range(0, 4088)),
                         rand_coord(r, $urandom_range(0, 4088))));
    end

    phase_idx = 0;
    while (items_sent < TARGET_ITEMS) begin
      metric = metric_e'($urandom_range(0, 1));
      case (phase_idx)
        0: count = 4;
        1: begin
          count = 256;
          metric = METRIC_EUCLID;
        end
        2: begin
          count = 511;
          metric = METRIC_MANHATTAN;
        end
        default: begin
          r = $urandom_range(0, 99);
          if (r < 8) count = 256;
          else if (r < 14) count = CNT_W'($urandom_range(257, 511));
          else if (r < 18) count = 0;
          else if (r < 24) count = 1;
          else if (r < 32) count = CNT_W'($urandom_range(33, 255));
          else count = CNT_W'($urandom_range(2, 32));
        end
      endcase
      n_items = (count > 32) ? $urandom_range(4, 10) : $urandom_range(30, 70);
      quiesce();
      no_idle = (phase_idx != 0) && ($urandom_range(0, 3) == 0);
      set_config(metric, count);
      if (phase_idx == 0) begin
        // The receiver holds off while queries keep coming, so the block backs up.
        hold_req = 1'b1;
        run_phase(count, 40, 90, 1'b0);
      end else begin
        run_phase(count, n_items, $urandom_range(50, 85), $urandom_range(0, 2) == 0);
      end
      phase_idx++;
    end

    no_idle = 1'b0;
    quiesce();
    $display("Checked %0d nearest seed results from %0d queries and %0d seed loads.",
             sb.results_checked, sb.queries_seen, sb.loads_seen);
    $display("Used %0d register settings across both metrics, seed counts 0 to 511.",
             settings_used);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
